/* design/svd_pkg.sv */
// svd_pkg: shared types, constants and command codes for the sparse vector store.
// Used by svd_ctrl, svd_dp and sparse_vector_store_dot. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svd_pkg;
    localparam int CAPACITY_DEF   = 256;
    localparam int INDEX_BITS_DEF = 16;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_DOT   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] entry_index;
        logic signed [31:0] entry_value;
        logic        last_entry;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic signed [31:0] read_value;
        logic signed [63:0] dot_sum;
        logic        dot_done;
        logic [8:0]  entry_count;
    } t_out_word;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input word, restart scan
        logic step;      // examine slot at scan pointer
        logic finish;    // apply the action and build the result
        logic clr_valid; // clear pass over valid bits
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic scan_end;  // last slot examined or match found
        logic clr_end;   // clear pass done
        logic mul_busy;  // product still in flight
    } t_stat;
endpackage
`default_nettype wire

/* design/sparse_vector_store_dot.sv */
// sparse_vector_store_dot: top level, joins controller and datapath.
// Depends on svd_pkg, svd_ctrl and svd_dp.
//
// Usage: one input channel (i_in_valid / o_in_stall / i_in_word) carries
// words of action, index, value and last flag; one output channel
// (o_out_valid / i_out_stall / o_out_word) returns exactly one result word
// per input word, in order.
// Operation: a write, read or dot word scans the slot table one slot per cycle
// through the index memory's single read port, stopping at the first match.
// A clear sweeps the valid bits one per cycle. One word is worked on at a
// time; the next word can be taken in the same cycle as the result is first presented.
// Reset (synchronous, active low) empties the store and zeroes the dot
// accumulator; no clearing pass is needed.
// While the receiver stalls, the result word is held; the next word may still
// be taken and scanned, and its result waits until the held word leaves.
`timescale 1ns / 1ps
`default_nettype none
module sparse_vector_store_dot #(
    parameter int CAPACITY   = svd_pkg::CAPACITY_DEF,
    parameter int INDEX_BITS = svd_pkg::INDEX_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire svd_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output svd_pkg::t_out_word      o_out_word
);
    svd_pkg::t_cmd  cmd;
    svd_pkg::t_stat stat;

    svd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_in_word.action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    svd_dp #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_in_word),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_word  (o_out_word)
    );
endmodule
`default_nettype wire

/* design/svd_ctrl.sv */
// svd_ctrl: controller state machine for the sparse vector store.
// Depends on svd_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module svd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_action,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output svd_pkg::t_cmd          o_cmd,
    input  wire svd_pkg::t_stat    i_stat
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_held;

    assign accept      = i_in_valid && !o_in_stall;
    assign out_held    = r_out_valid && i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = out_held;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_action == svd_pkg::ACT_CLEAR) ? S_CLR : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_end) n_state = S_MUL;
            end
            S_MUL: begin
                if (!i_stat.mul_busy) n_state = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result is still held
                if (!out_held) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.clr_valid = 1'b1;
                if (i_stat.clr_end) n_state = S_FIN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a held result word is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish |-> !(r_out_valid && i_out_stall)))
        else $error("finish while result stalled");
    // the result appears in the cycle after finish
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish |=> o_out_valid))
        else $error("finish without result");
    // commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("overlapping commands");
endmodule
`default_nettype wire

/* design/svd_dp.sv */
// svd_dp: datapath of the sparse vector store: slot memories, scan pointer,
// multiplier and saturating accumulator. Depends on svd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svd_dp #(
    parameter int CAPACITY   = svd_pkg::CAPACITY_DEF,
    parameter int INDEX_BITS = svd_pkg::INDEX_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire svd_pkg::t_in_word  i_word,
    input  wire svd_pkg::t_cmd      i_cmd,
    output svd_pkg::t_stat          o_stat,
    output svd_pkg::t_out_word      o_word
);
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // key width: the index field is 16 bits wide
    localparam int KW = (INDEX_BITS < 16) ? INDEX_BITS : 16;

    // slot stores: index and value live in memories, valid bits in flops
    logic [KW-1:0]         m_index [CAPACITY];
    logic [31:0]           m_value [CAPACITY];
    logic [CAPACITY-1:0]   r_valid;

    svd_pkg::t_in_word      r_in;
    svd_pkg::t_out_word     r_out;
    logic [CW-1:0]          r_count;
    logic [PW:0]            r_ptr;     // scan pointer, one past the last slot at end
    logic                   r_rd_vld;  // registered memory read is for r_rd_slot
    logic [PW-1:0]          r_rd_slot;
    logic [KW-1:0]          r_rd_index;
    logic [31:0]            r_rd_value;
    logic                   r_found, r_free_ok;
    logic [PW-1:0]          r_hit, r_free;
    logic [31:0]            r_hit_val;
    logic signed [63:0]     r_prod, r_acc;
    logic [1:0]             r_mul;     // multiply pipeline
    logic [PW-1:0]          r_clr;

    logic [KW-1:0]          key;
    logic                   issue, check_hit, all_issued, clr_last;
    logic signed [64:0]     sum_wide;
    logic signed [63:0]     sum_sat;

    assign key        = r_in.entry_index[KW-1:0];
    assign all_issued = r_ptr[PW] ||
                        (CAPACITY != (1 << PW) && r_ptr == (PW+1)'(CAPACITY));
    assign issue      = i_cmd.step && !all_issued && !r_found;
    assign check_hit  = r_rd_vld && r_valid[r_rd_slot] && (r_rd_index == key);
    assign clr_last   = (r_clr == PW'(CAPACITY - 1));

    assign o_stat.scan_end = i_cmd.step && (r_found || check_hit ||
                             (all_issued && !r_rd_vld));
    assign o_stat.clr_end  = clr_last;
    assign o_stat.mul_busy = |r_mul;
    assign o_word          = r_out;

    // saturating add of the product
    assign sum_wide = {r_acc[63], r_acc} + {r_prod[63], r_prod};
    always_comb begin
        if (sum_wide[64] != sum_wide[63])
            sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sum_sat = sum_wide[63:0];
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_index <= m_index[r_ptr[PW-1:0]];
            r_rd_value <= m_value[r_ptr[PW-1:0]];
            r_rd_slot  <= r_ptr[PW-1:0];
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_in.action == svd_pkg::ACT_WRITE
                && r_in.entry_value != 32'sd0) begin
            if (r_found) begin
                m_value[r_hit] <= r_in.entry_value;
            end else if (r_free_ok) begin
                m_index[r_free] <= key;
                m_value[r_free] <= r_in.entry_value;
            end
        end
    end

    // payload capture and product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_word;
        if (check_hit && !r_found) begin
            r_hit     <= r_rd_slot;
            r_hit_val <= r_rd_value;
        end
        r_prod <= $signed(r_hit_val) * $signed(r_in.entry_value);
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_acc     <= '0;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_free    <= '0;
            r_mul     <= '0;
            r_clr     <= '0;
            r_out     <= '0;
        end else begin
            r_mul <= {r_mul[0], 1'b0};
            if (i_cmd.load) begin
                r_ptr     <= '0;
                r_rd_vld  <= 1'b0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
                r_clr     <= '0;
            end
            // scan: find free slot from valid bits, match from memory
            if (i_cmd.step) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + 1'b1;
                    if (!r_free_ok && !r_valid[r_ptr[PW-1:0]]) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_ptr[PW-1:0];
                    end
                end
                if (check_hit && !r_found) begin
                    r_found <= 1'b1;
                    if (r_in.action == svd_pkg::ACT_DOT) r_mul <= 2'b01;
                end
            end
            if (i_cmd.clr_valid) begin
                r_valid[r_clr] <= 1'b0;
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out <= '0;
                case (r_in.action)
                    svd_pkg::ACT_WRITE: begin
                        if (r_in.entry_value == 32'sd0) begin
                            if (r_found) begin
                                r_valid[r_hit] <= 1'b0;
                                r_count <= r_count - 1'b1;
                                r_out.entry_count <= 9'(r_count - 1'b1);
                            end else r_out.entry_count <= 9'(r_count);
                        end else if (r_found) begin
                            r_out.entry_count <= 9'(r_count);
                        end else if (r_free_ok) begin
                            r_valid[r_free] <= 1'b1;
                            r_count <= r_count + 1'b1;
                            r_out.entry_count <= 9'(r_count + 1'b1);
                        end else begin
                            r_out.status      <= 1'b1;
                            r_out.entry_count <= 9'(r_count);
                        end
                    end
                    svd_pkg::ACT_READ: begin
                        r_out.read_value  <= r_found ? r_hit_val : 32'd0;
                        r_out.entry_count <= 9'(r_count);
                    end
                    svd_pkg::ACT_CLEAR: begin
                        r_count <= '0;
                    end
                    default: begin
                        r_out.entry_count <= 9'(r_count);
                        if (r_in.last_entry) begin
                            r_out.dot_done <= 1'b1;
                            r_out.dot_sum  <= r_found ? sum_sat : r_acc;
                            r_acc <= '0;
                        end else if (r_found) begin
                            r_acc <= sum_sat;
                        end
                    end
                endcase
            end
        end
    end

    // outside a clear, stored count matches the population of valid bits
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in.action != svd_pkg::ACT_CLEAR |-> r_count == CW'($countones(r_valid))))
        else $error("count and valid bits disagree");
    // the end of a scan is only reported while scanning
    a_hit_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.scan_end |-> i_cmd.step))
        else $error("scan end outside scan");
    // a dropped write only happens when the store is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_in.action == svd_pkg::ACT_WRITE && r_in.entry_value != 32'sd0
         && !r_found && !r_free_ok |-> r_count == CW'(CAPACITY)))
        else $error("write dropped with free slot");
endmodule
`default_nettype wire

/* tb/sparse_vector_store_dot_test.sv */
// sparse_vector_store_dot_test: self-checking bench for the sparse vector store
// with streaming dot product. Depends on svd_pkg and sparse_vector_store_dot.
`timescale 1ns / 1ps
module sparse_vector_store_dot_test;
    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    svd_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    svd_pkg::t_out_word o_out_word;

    sparse_vector_store_dot DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the store
    logic        vec_valid [CAP];
    logic [15:0] vec_index [CAP];
    logic [31:0] vec_value [CAP];
    int          vec_count;
    logic [63:0] dot_acc;

    svd_pkg::t_out_word expected_words [$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    bit        drain_done = 0;

    function automatic int slot_of(logic [15:0] idx);
        for (int i = 0; i < CAP; i++)
            if (vec_valid[i] && vec_index[i] == idx) return i;
        return -1;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    // model one word, push its expected result
    task automatic predict_word(svd_pkg::t_in_word w);
        svd_pkg::t_out_word r;
        int s;
        logic signed [63:0] prod;
        r = '0;
        s = slot_of(w.entry_index);
        case (w.action)
            svd_pkg::ACT_WRITE: begin
                if (w.entry_value == 0) begin
                    if (s >= 0) begin
                        vec_valid[s] = 1'b0;
                        vec_count--;
                    end
                end else if (s >= 0) begin
                    vec_value[s] = w.entry_value;
                end else begin
                    s = -1;
                    for (int i = 0; i < CAP; i++)
                        if (s < 0 && !vec_valid[i]) s = i;
                    if (s < 0) r.status = 1'b1;
                    else begin
                        vec_valid[s] = 1'b1;
                        vec_index[s] = w.entry_index;
                        vec_value[s] = w.entry_value;
                        vec_count++;
                    end
                end
            end
            svd_pkg::ACT_READ: if (s >= 0) r.read_value = vec_value[s];
            svd_pkg::ACT_CLEAR: begin
                for (int i = 0; i < CAP; i++) vec_valid[i] = 1'b0;
                vec_count = 0;
            end
            default: begin
                if (s >= 0) begin
                    prod = $signed(vec_value[s]) * $signed(w.entry_value);
                    dot_acc = add_sat(dot_acc, prod);
                end
                if (w.last_entry) begin
                    r.dot_sum = dot_acc;
                    r.dot_done = 1'b1;
                    dot_acc = '0;
                end
            end
        endcase
        r.entry_count = vec_count[8:0];
        expected_words.push_back(r);
    endtask

    // send one word after a random gap; valid stays up when there is no gap
    task automatic send_word(logic [1:0] act, logic [15:0] idx, logic [31:0] val, logic lst);
        svd_pkg::t_in_word w;
        int gap;
        w.action = act;
        w.entry_index = idx;
        w.entry_value = val;
        w.last_entry = lst;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(w);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                fail_count++;
            end else begin
                svd_pkg::t_out_word e;
                e = expected_words.pop_front();
                if (e.status !== o_out_word.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status,
                             o_out_word.status);
                    fail_count++;
                end
                if (e.read_value !== o_out_word.read_value) begin
                    $display("%0t: read_value exp %h got %h", $time, e.read_value,
                             o_out_word.read_value);
                    fail_count++;
                end
                if (e.dot_sum !== o_out_word.dot_sum) begin
                    $display("%0t: dot_sum exp %h got %h", $time, e.dot_sum,
                             o_out_word.dot_sum);
                    fail_count++;
                end
                if (e.dot_done !== o_out_word.dot_done) begin
                    $display("%0t: dot_done exp %0d got %0d", $time, e.dot_done,
                             o_out_word.dot_done);
                    fail_count++;
                end
                if (e.entry_count !== o_out_word.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                             o_out_word.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall: each presented result may be stalled at random before it is taken
    int stall_left = 0;
    int stall_draw;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && i_out_stall == 1'b0) begin
            stall_draw = $urandom_range(0, 9);
            if (stall_draw > 0) begin
                stall_left <= stall_draw - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted input word and no taken result
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !drain_done) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_word(svd_pkg::ACT_READ, 16'h0000, 32'h0, 1'b1);
        send_word(svd_pkg::ACT_WRITE, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        send_word(svd_pkg::ACT_WRITE, 16'hFFFF, 32'h8000_0000, 1'b1);
        send_word(svd_pkg::ACT_WRITE, 16'h1234, 32'h0, 1'b0);       // remove absent
        send_word(svd_pkg::ACT_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(svd_pkg::ACT_WRITE, 16'hFFFF, 32'h0002_0000, 1'b0); // overwrite
        send_word(svd_pkg::ACT_READ, 16'hFFFF, 32'h0, 1'b0);
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b0); // repeated index
        send_word(svd_pkg::ACT_DOT, 16'h5555, 32'h1234_5678, 1'b0); // absent index
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b1); // saturate high
        send_word(svd_pkg::ACT_WRITE, 16'h0000, 32'h8000_0000, 1'b0);
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        send_word(svd_pkg::ACT_DOT, 16'h0000, 32'h7FFF_FFFF, 1'b1); // saturate low
        send_word(svd_pkg::ACT_DOT, 16'hFFFF, 32'h8000_0000, 1'b0);
        send_word(svd_pkg::ACT_CLEAR, 16'hAAAA, 32'h1, 1'b1);       // accumulator kept
        send_word(svd_pkg::ACT_DOT, 16'hFFFF, 32'h1, 1'b1);
        send_word(svd_pkg::ACT_WRITE, 16'h0000, 32'h0, 1'b1);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < CAP; i++)
            send_word(svd_pkg::ACT_WRITE, 16'(i * 7 + 3), rand_value() | 32'h1, 1'b0);
        send_word(svd_pkg::ACT_WRITE, 16'hFFFE, 32'h0001_0000, 1'b0); // dropped
        send_word(svd_pkg::ACT_WRITE, 16'h0003, 32'h0000_0005, 1'b0); // overwrite when full
        send_word(svd_pkg::ACT_WRITE, 16'h000A, 32'h0, 1'b0);         // remove frees one
        send_word(svd_pkg::ACT_WRITE, 16'hFFFE, 32'h0001_0000, 1'b0);
        send_word(svd_pkg::ACT_READ, 16'hFFFE, 32'h0, 1'b0);
        send_word(svd_pkg::ACT_CLEAR, 16'h0, 32'h0, 1'b0);
    endtask

    task automatic test_random();
        logic [15:0] idx;
        for (int n = 0; n < 118; n++) begin
            idx = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 31));
            case ($urandom_range(0, 19))
                0: send_word(svd_pkg::ACT_CLEAR, 16'($urandom()), $urandom(), 1'($urandom()));
                1, 2, 3, 4, 5, 6:
                    send_word(svd_pkg::ACT_WRITE, idx,
                              $urandom_range(0, 4) == 0 ? 32'h0 : rand_value(),
                              1'($urandom()));
                7, 8, 9: send_word(svd_pkg::ACT_READ, idx, $urandom(), 1'($urandom()));
                default: send_word(svd_pkg::ACT_DOT, idx, rand_value(),
                                   $urandom_range(0, 4) == 0);
            endcase
        end
        send_word(svd_pkg::ACT_DOT, 16'h0, 32'h0, 1'b1);
    endtask

    initial begin
        for (int i = 0; i < CAP; i++) vec_valid[i] = 1'b0;
        vec_count = 0;
        dot_acc = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_store();
        test_random();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (CAP + 10) @(posedge i_clk);
        drain_done = 1;
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
